/* src/acpi_pm_timer_read_unit_assert.svh */
// Assertion macros shared by the timer read unit and its divider.
// Both sample on clock and are off while reset is high.
`ifndef ACPI_PM_TIMER_READ_UNIT_ASSERT_SVH
`define ACPI_PM_TIMER_READ_UNIT_ASSERT_SVH

// Same-cycle implication.
`define APT_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define APT_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/apt_pkg.sv */
package apt_pkg;

   localparam int unsigned TICK_RATE_HZ_DEF = 3579545;
   localparam int unsigned NSEC_PER_SEC     = 1000000000;

   localparam int unsigned BYTES_W  = 3;
   localparam int unsigned STAMP_W  = 64;
   localparam int unsigned SEC_W    = 32;
   localparam int unsigned NSEC_W   = 30;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned FREQ_W   = 40;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned MUL_W    = 32;

   localparam logic [BYTES_W-1:0] VALID_ACCESS_BYTES = 3'd4;
   localparam logic [FREQ_W-1:0]  CYCLE_FREQ_RESET   = 40'd2000000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLOCK_SOURCE = 1'b0,
      CSR_CYCLE_FREQ   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_SIZE  = 2'd1,
      STATUS_BACKWARDS = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NS,
      ST_DIFF,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIV_GO,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

/* src/apt_if.sv */
interface apt_req_if import apt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTES_W-1:0]  access_bytes;
   logic [STAMP_W-1:0]  cycle_stamp;
   logic [SEC_W-1:0]    uptime_sec;
   logic [NSEC_W-1:0]   uptime_nsec;

   modport source (output valid, access_bytes, cycle_stamp, uptime_sec, uptime_nsec,
                   input ready);
   modport sink   (input valid, access_bytes, cycle_stamp, uptime_sec, uptime_nsec,
                   output ready);
endinterface

interface apt_rsp_if import apt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  read_data;
   status_type         status;

   modport source (output valid, read_data, status, input ready);
   modport sink   (input valid, read_data, status, output ready);
endinterface

interface apt_csr_if import apt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [FREQ_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* src/apt_div.sv */
`include "acpi_pm_timer_read_unit_assert.svh"

// Restoring divider, one quotient bit per cycle. Quotient bits shift into
// the dividend register as its top bits move into the remainder.
module apt_div import apt_pkg::*; #(
   parameter int unsigned DVD_W = 86,
   parameter int unsigned DSR_W = FREQ_W,
   parameter int unsigned QUO_W = STAMP_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [DSR_W-1:0]  divisor,
   output div_sts_type       sts,
   output logic [QUO_W-1:0]  quotient
);

   localparam int unsigned CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] divisor_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DSR_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      fits    = (trial >= {1'b0, divisor_ff});
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], fits};
         rem_in = fits ? DSR_W'(trial - {1'b0, divisor_ff}) : trial[DSR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (start) begin
         divisor_ff <= divisor;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = dvd_ff[QUO_W-1:0];

   `APT_ASSERT_NXT(a_start_busy, start, busy_ff, "divider did not go busy on start")
   `APT_ASSERT_IMP(a_divisor_nz, busy_ff, divisor_ff != '0, "divider running on zero divisor")
   `APT_ASSERT_IMP(a_rem_below, busy_ff, rem_ff < divisor_ff, "partial remainder not below divisor")

endmodule

/* src/acpi_pm_timer_read_unit.sv */
// A good four-byte read steps through the NS, DIFF, MUL_LO, MUL_HI, DIV_GO, DIV and DONE
//   states, staying in DIV while the bit-serial divider runs; a bad size goes straight
//   to DONE, and a backwards stamp leaves DIFF for DONE.
// One read at a time is taken; a result held at the output stalls the sequencer.
// Reset (synchronous, active high): timer unanchored, count and stamps zero,
//   clock_source = 0, cycle_freq_hz = 2000000000, no result pending.
`include "acpi_pm_timer_read_unit_assert.svh"

module acpi_pm_timer_read_unit import apt_pkg::*; #(
   parameter int unsigned TICK_RATE_HZ = TICK_RATE_HZ_DEF
) (
   input  logic   clock,
   input  logic   reset,
   apt_csr_if.sink   csr_bus,
   apt_req_if.sink   req_bus,
   apt_rsp_if.source rsp_bus
);

   // Tick rate width and the width of elapsed * tick rate.
   localparam int unsigned TICK_W = $clog2(TICK_RATE_HZ + 1);
   localparam int unsigned DVD_W  = STAMP_W + TICK_W;
   localparam logic [MUL_W-1:0] TICK_MUL = MUL_W'(TICK_RATE_HZ);
   localparam logic [MUL_W-1:0] NSEC_MUL = MUL_W'(NSEC_PER_SEC);

   // Configuration registers.
   logic              clock_source_ff;
   logic [FREQ_W-1:0] cycle_freq_ff;

   // Timer state.
   logic               started_ff;
   logic [STAMP_W-1:0] tick_total_ff;
   logic [STAMP_W-1:0] last_cyc_ff;
   logic [STAMP_W-1:0] last_ns_ff;

   // Per-transaction working registers.
   state_type          state_ff, state_in;
   status_type         status_ff;
   logic [STAMP_W-1:0] cyc_ff;
   logic [SEC_W-1:0]   sec_ff;
   logic [NSEC_W-1:0]  nsec_ff;
   logic [STAMP_W-1:0] now_ns_ff;
   logic [STAMP_W-1:0] elapsed_ff;
   logic [DVD_W-1:0]   prod_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  rsp_data_ff;
   status_type         rsp_status_ff;

   // Shared multiplier and sequencer controls.
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [2*MUL_W-1:0] mul_out;
   logic               div_start;
   logic               commit;
   logic               req_fire;
   logic               out_free;
   logic [STAMP_W-1:0] now_sel, last_sel;
   logic               backwards;
   logic [FREQ_W-1:0]  divisor;
   logic [STAMP_W-1:0] quotient;
   logic [STAMP_W-1:0] total_new;
   div_sts_type        div_sts;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   // Configuration writes must land while the block is idle; the block does not enforce it and takes them all.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_source_ff <= 1'b0;
         cycle_freq_ff   <= CYCLE_FREQ_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_CLOCK_SOURCE: clock_source_ff <= csr_bus.data[0];
            CSR_CYCLE_FREQ:   cycle_freq_ff   <= csr_bus.data;
            default:          ;
         endcase
      end
   end

   // Pick the stamp and the stored stamp of the active clock; a zero
   // frequency divides as one.
   always_comb begin
      now_sel   = clock_source_ff ? now_ns_ff : cyc_ff;
      last_sel  = clock_source_ff ? last_ns_ff : last_cyc_ff;
      backwards = started_ff && (now_sel < last_sel);
      if (clock_source_ff) begin
         divisor = FREQ_W'(NSEC_PER_SEC);
      end else if (cycle_freq_ff == '0) begin
         divisor = FREQ_W'(1);
      end else begin
         divisor = cycle_freq_ff;
      end
   end

   // Shared 32x32 multiplier: uptime seconds to nanoseconds, then the low
   // and high halves of elapsed * tick rate.
   assign mul_out = mul_a * mul_b;

   apt_div #(
      .DVD_W (DVD_W),
      .DSR_W (FREQ_W),
      .QUO_W (STAMP_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (divisor),
      .sts      (div_sts),
      .quotient (quotient)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_bus.access_bytes == VALID_ACCESS_BYTES) ? ST_NS : ST_DONE;
            end
         end
         ST_NS:     state_in = ST_DIFF;
         ST_DIFF:   state_in = backwards ? ST_DONE : ST_MUL_LO;
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_DIV_GO;
         ST_DIV_GO: state_in = ST_DIV;
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      mul_a         = sec_ff;
      mul_b         = NSEC_MUL;
      div_start     = 1'b0;
      commit        = 1'b0;
      req_bus.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_bus.ready = 1'b1;
         ST_MUL_LO: begin
            mul_a = elapsed_ff[MUL_W-1:0];
            mul_b = TICK_MUL;
         end
         ST_MUL_HI: begin
            mul_a = elapsed_ff[STAMP_W-1:MUL_W];
            mul_b = TICK_MUL;
         end
         ST_DIV_GO: div_start = 1'b1;
         ST_DONE:   commit = out_free;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working registers: capture the transaction, then advance per step.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cyc_ff    <= req_bus.cycle_stamp;
         sec_ff    <= req_bus.uptime_sec;
         nsec_ff   <= req_bus.uptime_nsec;
         status_ff <= (req_bus.access_bytes == VALID_ACCESS_BYTES) ? STATUS_OK
                                                                    : STATUS_BAD_SIZE;
      end
      unique case (state_ff)
         ST_NS:     now_ns_ff <= mul_out + STAMP_W'(nsec_ff);
         ST_DIFF: begin
            elapsed_ff <= started_ff ? (now_sel - last_sel) : now_sel;
            if (backwards) begin
               status_ff <= STATUS_BACKWARDS;
            end
         end
         ST_MUL_LO: prod_ff <= DVD_W'(mul_out);
         ST_MUL_HI: prod_ff <= prod_ff + (DVD_W'(mul_out) << MUL_W);
         default:   ;
      endcase
   end

   // First valid read anchors; later ones accumulate, wrapping at 64 bits.
   assign total_new = started_ff ? (tick_total_ff + quotient) : quotient;

   // Timer state: commit only a good read, as it leaves for the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         tick_total_ff <= '0;
         last_cyc_ff   <= '0;
         last_ns_ff    <= '0;
      end else if (commit && (status_ff == STATUS_OK)) begin
         started_ff    <= 1'b1;
         tick_total_ff <= total_new;
         last_cyc_ff   <= cyc_ff;
         last_ns_ff    <= now_ns_ff;
      end
   end

   // Output register: load on commit, drop once the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff   <= (status_ff == STATUS_OK) ? total_new[DATA_W-1:0] : '0;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_data = rsp_data_ff;
   assign rsp_bus.status    = rsp_status_ff;

   `APT_ASSERT_IMP(a_err_zero, rsp_valid_ff && (rsp_status_ff != STATUS_OK), rsp_data_ff == '0, "error transaction carries nonzero data")
   `APT_ASSERT_NXT(a_bad_size, req_fire && (req_bus.access_bytes != VALID_ACCESS_BYTES), (state_ff == ST_DONE) && (status_ff == STATUS_BAD_SIZE), "bad access size not flagged")
   `APT_ASSERT_NXT(a_anchor, commit && (status_ff == STATUS_OK), started_ff && rsp_valid_ff, "good read did not anchor timer")

endmodule
